### sv/pft_pkg.sv
// shared constants and types for the polygon fan triangulator
package pft_pkg;

  localparam int MAX_INPUTS_DEF = 8;
  localparam int WORD_W         = 32;
  localparam int CFG_W          = 4;
  localparam int BANK_W         = 2;

  // bank numbers of the three tuple buffers in the tuple ram
  localparam logic [BANK_W-1:0] BANK_A = 2'd0;
  localparam logic [BANK_W-1:0] BANK_B = 2'd1;
  localparam logic [BANK_W-1:0] BANK_C = 2'd2;

  // corner select codes used while a triangle is read out
  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_PREV  = 2'd1;
  localparam logic [1:0] CORNER_CUR   = 2'd2;

  typedef struct packed {
    logic              go;
    logic [BANK_W-1:0] bank_first;
    logic [BANK_W-1:0] bank_prev;
    logic [BANK_W-1:0] bank_cur;
    logic [WORD_W-1:0] tri_num;
  } emit_req_t;

endpackage

### sv/pft_tuple_ram.sv
// tuple ram: one write port, one read port with registered read data
module pft_tuple_ram
  import pft_pkg::*;
#(
  parameter int DEPTH = 3 * MAX_INPUTS_DEF,
  parameter int AW    = $clog2(3 * MAX_INPUTS_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/pft_emit_seq.sv
// triangle readout sequencer: walks first, previous and current tuple one word a cycle while out_stall allows
module pft_emit_seq
  import pft_pkg::*;
#(
  parameter int MAX_INPUTS = MAX_INPUTS_DEF,
  parameter int CW         = $clog2(MAX_INPUTS + 1),
  parameter int AW         = $clog2(3 * MAX_INPUTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  emit_req_t         req,
  input  logic [CW-1:0]     n_eff,
  input  logic              out_stall,
  output logic              busy,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  output logic              out_valid,
  output logic              out_last,
  output logic [WORD_W-1:0] out_tri
);

  logic              busy_r, busy_nxt;
  logic [1:0]        sel_r, sel_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [BANK_W-1:0] bank_first_r, bank_prev_r, bank_cur_r;
  logic [WORD_W-1:0] tri_r;
  logic              out_valid_r, out_valid_nxt;
  logic              last_r;
  logic [WORD_W-1:0] out_tri_r;
  logic [BANK_W-1:0] bank_sel;
  logic              word_last;
  logic              tri_last;

  // read when the output slot is empty or being taken this cycle
  assign rd_en     = busy_r && (!out_valid_r || !out_stall);
  assign word_last = (pos_r == n_eff - CW'(1));
  assign tri_last  = word_last && (sel_r == CORNER_CUR);

  always_comb begin
    case (sel_r)
      CORNER_FIRST: bank_sel = bank_first_r;
      CORNER_PREV:  bank_sel = bank_prev_r;
      CORNER_CUR:   bank_sel = bank_cur_r;
      default:      bank_sel = bank_cur_r;
    endcase
  end

  assign rd_addr = AW'(bank_sel) * AW'(MAX_INPUTS) + AW'(pos_r);

  always_comb begin
    busy_nxt      = busy_r;
    sel_nxt       = sel_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    if (rd_en) begin
      out_valid_nxt = 1'b1;
      if (word_last) begin
        pos_nxt = '0;
        sel_nxt = sel_r + 2'd1;
        if (sel_r == CORNER_CUR) begin
          busy_nxt = 1'b0;
        end
      end else begin
        pos_nxt = pos_r + CW'(1);
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (req.go && !busy_r) begin
      busy_nxt = 1'b1;
      sel_nxt  = CORNER_FIRST;
      pos_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      sel_r       <= CORNER_FIRST;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      sel_r       <= sel_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go && !busy_r) begin
      bank_first_r <= req.bank_first;
      bank_prev_r  <= req.bank_prev;
      bank_cur_r   <= req.bank_cur;
      tri_r        <= req.tri_num;
    end
    if (rd_en) begin
      last_r    <= tri_last;
      out_tri_r <= tri_last ? tri_r : '0;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_last  = last_r;
  assign out_tri   = out_tri_r;

endmodule

### sv/polygon_fan_triangulator_unit.sv
// polygon fan triangulator: tuple collection, bank rotation and triangle readout
// start: an item that completes the third or later tuple of a polygon starts a triangle;
// busy is registered, then the ram read; then all 3*n words follow one per cycle (n = input_count)
// flow: items that emit nothing are accepted without stalling; triangle readout is bounded by
// the tuple ram's single read port; input stalls during readout, and out_stall holds the readout
// reset: synchronous active-low, clears counters, bank roles and input_count to 1; ram holds junk
module polygon_fan_triangulator_unit
  import pft_pkg::*;
#(
  parameter int MAX_INPUTS = MAX_INPUTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] in_index_value,
  input  logic              in_polygon_start,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_index_out,
  output logic [WORD_W-1:0] out_triangle_number,
  output logic              out_last_of_triangle
);

  localparam int CW = $clog2(MAX_INPUTS + 1);
  localparam int AW = $clog2(3 * MAX_INPUTS);
  localparam int XW = (CW > CFG_W + 1) ? CW : CFG_W + 1;

  logic [CFG_W-1:0]  cfg_r;
  logic [CW-1:0]     n_eff;
  logic [XW-1:0]     cfg_ext;
  logic [CW-1:0]     pos_r;
  logic [1:0]        seen_r;
  logic [BANK_W-1:0] first_bank_r, prev_bank_r, cur_bank_r;
  logic [WORD_W-1:0] tri_total_r;
  logic              in_acc;
  logic [CW-1:0]     pos_eff;
  logic [1:0]        seen_eff;
  logic              tuple_done;
  logic              emit_busy;
  emit_req_t         req;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;

  // zero counts as one, anything above the buffer size saturates
  assign cfg_ext = XW'(cfg_r);
  always_comb begin
    priority if (cfg_r == '0) begin
      n_eff = CW'(1);
    end else if (cfg_ext > XW'(MAX_INPUTS)) begin
      n_eff = CW'(MAX_INPUTS);
    end else begin
      n_eff = CW'(cfg_ext);
    end
  end

  assign in_stall = emit_busy;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    pos_eff  = in_polygon_start ? '0 : pos_r;
    seen_eff = in_polygon_start ? 2'd0 : seen_r;
    if (pos_eff >= n_eff) begin
      pos_eff = '0;
    end
  end

  assign tuple_done = (pos_eff + CW'(1) == n_eff);
  assign wr_addr    = AW'(cur_bank_r) * AW'(MAX_INPUTS) + AW'(pos_eff);

  assign req.go         = in_acc && tuple_done && (seen_eff == 2'd2);
  assign req.bank_first = first_bank_r;
  assign req.bank_prev  = prev_bank_r;
  assign req.bank_cur   = cur_bank_r;
  assign req.tri_num    = tri_total_r + WORD_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= CFG_W'(1);
      pos_r        <= '0;
      seen_r       <= 2'd0;
      first_bank_r <= BANK_A;
      prev_bank_r  <= BANK_B;
      cur_bank_r   <= BANK_C;
      tri_total_r  <= '0;
    end else if (cfg_wr_en) begin
      cfg_r  <= cfg_wr_data;
      pos_r  <= '0;
      seen_r <= 2'd0;
    end else if (in_acc) begin
      if (!tuple_done) begin
        pos_r  <= pos_eff + CW'(1);
        seen_r <= seen_eff;
      end else begin
        pos_r <= '0;
        // the finished tuple's bank takes its new role, the freed bank becomes current
        unique case (seen_eff)
          2'd0: begin
            first_bank_r <= cur_bank_r;
            cur_bank_r   <= first_bank_r;
            seen_r       <= 2'd1;
          end
          2'd1: begin
            prev_bank_r <= cur_bank_r;
            cur_bank_r  <= prev_bank_r;
            seen_r      <= 2'd2;
          end
          default: begin
            prev_bank_r <= cur_bank_r;
            cur_bank_r  <= prev_bank_r;
            seen_r      <= 2'd2;
            tri_total_r <= tri_total_r + WORD_W'(1);
          end
        endcase
      end
    end
  end

  pft_tuple_ram #(
    .DEPTH (3 * MAX_INPUTS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wr_addr),
    .wr_data (in_index_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (out_index_out)
  );

  pft_emit_seq #(
    .MAX_INPUTS (MAX_INPUTS),
    .CW         (CW),
    .AW         (AW)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .n_eff     (n_eff),
    .out_stall (out_stall),
    .busy      (emit_busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .out_valid (out_valid),
    .out_last  (out_last_of_triangle),
    .out_tri   (out_triangle_number)
  );

  // the three tuple buffers never share a bank
  a_banks_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (first_bank_r != prev_bank_r) && (first_bank_r != cur_bank_r) &&
    (prev_bank_r != cur_bank_r))
    else $error("tuple bank roles overlap");

  // a triangle request always starts the readout
  a_go_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |=> emit_busy)
    else $error("triangle request did not start readout");

  // readout only begins after a polygon had two finished tuples
  a_emit_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(emit_busy) |-> $past(seen_r) == 2'd2 && $past(in_polygon_start) == 1'b0)
    else $error("readout started without two tuples");

  // non-final words carry a zero triangle number
  a_tri_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_triangle) |-> (out_triangle_number == '0))
    else $error("triangle number on a non-final word");

endmodule
